>>> sv/scae_pkg.sv
package scae_pkg;

  localparam logic [7:0] LEAD_BYTE  = 8'hC2;
  localparam logic [7:0] TRAIL_BYTE = 8'hA7;
  localparam logic [7:0] ESC_BYTE   = 8'h1B;
  localparam logic [7:0] CHR_LBR    = 8'h5B;
  localparam logic [7:0] CHR_M      = 8'h6D;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] NUL_BYTE   = 8'h00;

  localparam int unsigned NUM_SLOTS           = 8;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  // output slots of one command, sent lowest first
  localparam logic [2:0] SLOT_PRE   = 3'd0;
  localparam logic [2:0] SLOT_BODY  = 3'd1;
  localparam logic [2:0] SLOT_LBR   = 3'd2;
  localparam logic [2:0] SLOT_TENS  = 3'd3;
  localparam logic [2:0] SLOT_ONES  = 3'd4;
  localparam logic [2:0] SLOT_M     = 3'd5;
  localparam logic [2:0] SLOT_POST  = 3'd6;
  localparam logic [2:0] SLOT_EMPTY = 3'd7;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic [7:0]           body;
    logic [7:0]           tens;
    logic [7:0]           ones;
    logic                 last;
  } cmd_t;

  typedef struct packed {
    logic       hit;
    logic       two_digit;
    logic [3:0] tens;
    logic [3:0] ones;
  } code_t;

  function automatic code_t code_lookup(input logic [7:0] b);
    code_t r;
    r = '{hit: 1'b0, two_digit: 1'b0, tens: 4'd0, ones: 4'd0};
    unique case (b)
      8'h30: r = '{1'b1, 1'b1, 4'd3, 4'd0};
      8'h31: r = '{1'b1, 1'b1, 4'd3, 4'd4};
      8'h32: r = '{1'b1, 1'b1, 4'd3, 4'd2};
      8'h33: r = '{1'b1, 1'b1, 4'd3, 4'd6};
      8'h34: r = '{1'b1, 1'b1, 4'd3, 4'd1};
      8'h35: r = '{1'b1, 1'b1, 4'd3, 4'd5};
      8'h36: r = '{1'b1, 1'b1, 4'd3, 4'd3};
      8'h37: r = '{1'b1, 1'b1, 4'd3, 4'd7};
      8'h38: r = '{1'b1, 1'b1, 4'd9, 4'd0};
      8'h39: r = '{1'b1, 1'b1, 4'd9, 4'd4};
      8'h61: r = '{1'b1, 1'b1, 4'd9, 4'd2};
      8'h62: r = '{1'b1, 1'b1, 4'd9, 4'd6};
      8'h63: r = '{1'b1, 1'b1, 4'd9, 4'd1};
      8'h64: r = '{1'b1, 1'b1, 4'd9, 4'd5};
      8'h65: r = '{1'b1, 1'b1, 4'd9, 4'd3};
      8'h66: r = '{1'b1, 1'b1, 4'd9, 4'd7};
      8'h6C: r = '{1'b1, 1'b0, 4'd0, 4'd1};
      8'h6D: r = '{1'b1, 1'b0, 4'd0, 4'd9};
      8'h6E: r = '{1'b1, 1'b0, 4'd0, 4'd4};
      8'h6F: r = '{1'b1, 1'b0, 4'd0, 4'd3};
      8'h72: r = '{1'b1, 1'b0, 4'd0, 4'd0};
      default: r = '{1'b0, 1'b0, 4'd0, 4'd0};
    endcase
    return r;
  endfunction

endpackage

>>> sv/section_code_to_ansi_escape_top.sv
// channel | direction | handshake            | payload
// input   | in        | in_valid / in_stall  | in_byte, in_last
// output  | out       | out_valid / out_stall| out_byte, has_byte, out_last
//
// one input transaction a cycle while in_stall is low; a plain byte leaves as one
// output transaction, a format sequence as up to five, one a cycle while out_stall
// is low, paced by the output register after the queue and the slot mask register
// reset (rst, synchronous) clears the phase, the queue and the output valid
// in_stall rises only when the command queue is full; out_stall holds the
// output register, and the queue lets the front go on meanwhile
module section_code_to_ansi_escape_top #(
  parameter int unsigned QUEUE_DEPTH = scae_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       out_last
);
  import scae_pkg::*;

  // commands from the classifier to the emitter
  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic q_full;
  logic q_valid;
  logic q_pop;

  // front: tracks the section sign and turns each byte into a slot mask
  scae_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .q_push   (push),
    .q_cmd    (push_cmd)
  );

  // short queue so that a stalled output does not stop the front at once
  scae_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (pop_cmd)
  );

  // back: walks the slot mask and sends one byte per output transaction
  scae_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .has_byte  (has_byte),
    .out_last  (out_last)
  );

endmodule

>>> sv/scae_front.sv
module scae_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          q_full,
  output logic          q_push,
  output scae_pkg::cmd_t q_cmd
);
  import scae_pkg::*;

  typedef enum logic [2:0] {
    PH_PLAIN = 3'b001,
    PH_HELD  = 3'b010,
    PH_CODE  = 3'b100
  } phase_t;

  phase_t               phase;
  phase_t               phase_next;
  code_t                look;
  logic [NUM_SLOTS-1:0] mask;
  logic [7:0]           body;
  logic                 accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    look       = code_lookup(in_byte);
    mask       = '0;
    body       = in_byte;
    phase_next = PH_PLAIN;
    unique case (phase)
      PH_HELD: begin
        if (in_byte == TRAIL_BYTE) begin
          phase_next = PH_CODE;
        end else begin
          mask[SLOT_PRE] = 1'b1;
          if (in_byte == LEAD_BYTE) begin
            phase_next = PH_HELD;
          end else begin
            mask[SLOT_BODY] = 1'b1;
          end
        end
      end
      PH_CODE: begin
        if (look.hit) begin
          body            = ESC_BYTE;
          mask[SLOT_BODY] = 1'b1;
          mask[SLOT_LBR]  = 1'b1;
          mask[SLOT_TENS] = look.two_digit;
          mask[SLOT_ONES] = 1'b1;
          mask[SLOT_M]    = 1'b1;
        end
      end
      default: begin
        if (in_byte == LEAD_BYTE) begin
          phase_next = PH_HELD;
        end else begin
          mask[SLOT_BODY] = 1'b1;
        end
      end
    endcase
    if (in_last) begin
      // a lead byte still held goes out as the last byte, carrying the end mark
      if (phase_next == PH_HELD) begin
        mask[SLOT_POST] = 1'b1;
      end
      phase_next = PH_PLAIN;
      if (mask == '0) begin
        mask[SLOT_EMPTY] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PLAIN;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  assign q_push     = accept && (mask != '0);
  assign q_cmd.mask = mask;
  assign q_cmd.body = body;
  assign q_cmd.tens = CHR_ZERO + {4'd0, look.tens};
  assign q_cmd.ones = CHR_ZERO + {4'd0, look.ones};
  assign q_cmd.last = in_last;

endmodule

>>> sv/scae_queue.sv
module scae_queue #(
  parameter int unsigned DEPTH = scae_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  scae_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output scae_pkg::cmd_t pop_cmd
);
  import scae_pkg::*;

  localparam int unsigned AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/scae_back.sv
module scae_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  scae_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           has_byte,
  output logic           out_last
);
  import scae_pkg::*;

  cmd_t                 cur_cmd;
  logic [NUM_SLOTS-1:0] cur_mask;
  logic [NUM_SLOTS-1:0] mask_after;
  logic [2:0]           slot;
  logic [7:0]           slot_byte;
  logic                 can_emit;
  logic                 emit;
  logic                 cur_free;

  // lowest pending slot
  always_comb begin
    slot = SLOT_EMPTY;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (cur_mask[i]) begin
        slot = 3'(i);
      end
    end
  end

  assign mask_after = cur_mask & (cur_mask - 1'b1);
  assign can_emit   = !out_valid || !out_stall;
  assign emit       = can_emit && (cur_mask != '0);
  assign cur_free   = (cur_mask == '0) || (emit && (mask_after == '0));
  assign q_pop      = cur_free && q_valid;

  always_comb begin
    unique case (slot)
      SLOT_PRE:   slot_byte = LEAD_BYTE;
      SLOT_BODY:  slot_byte = cur_cmd.body;
      SLOT_LBR:   slot_byte = CHR_LBR;
      SLOT_TENS:  slot_byte = cur_cmd.tens;
      SLOT_ONES:  slot_byte = cur_cmd.ones;
      SLOT_M:     slot_byte = CHR_M;
      SLOT_POST:  slot_byte = LEAD_BYTE;
      SLOT_EMPTY: slot_byte = NUL_BYTE;
      default:    slot_byte = NUL_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask <= '0;
    end else if (q_pop) begin
      cur_mask <= q_cmd.mask;
    end else if (emit) begin
      cur_mask <= mask_after;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_cmd <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_emit) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= slot_byte;
      has_byte <= (slot != SLOT_EMPTY);
      out_last <= cur_cmd.last && (mask_after == '0);
    end
  end

endmodule

>>> sv/scae_checker.sv
module scae_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       has_byte,
  input logic       out_last
);

  // after reset nothing is pending and input is open
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("block not idle after reset");

  // an empty result only ever stands as the end mark
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_byte) |-> (out_last && (out_byte == 8'h00)))
    else $error("empty result without end mark");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("output valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      ($stable(out_byte) && $stable(has_byte) && $stable(out_last)))
    else $error("output payload changed while stalled");

endmodule

bind section_code_to_ansi_escape_top scae_checker u_checker (.*);
